// ===== rtl/sha256_pkg.sv =====
// Package for the SHA-256 hasher: beat types, constants and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned LEN_WORD    = 14;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

// ===== rtl/sha256_message_hasher.sv =====
// SHA-256 hasher top level: byte gathering, padding, round engine, digest output.
// Input: a byte beat is taken in the idle state; a beat that fills a block holds input off
//   through the round states and the hash add state.
// End beat: padding at 1 byte a cycle up to byte 55 (through 63 and again from 0 when
//   it spills), a compression per block, then 8 digest beats; input waits meanwhile.
// One message at a time: no byte is taken outside idle. Reset: rst_n (async, active
//   low) loads the initial hash and clears counts.
`timescale 1ns / 1ps
module sha256_message_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_beat_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;

    // block memory: 16 words, one byte lane write, one read port
    logic [31:0] blk_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;

    logic [31:0] hash_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;
    logic [3:0]  cnt_reg;
    logic        finish_reg;
    logic        last_blk_reg;
    logic [2:0]  oidx_reg;

    logic        take;
    logic        byte_we;
    logic [5:0]  byte_addr;
    logic [7:0]  byte_val;

    logic [31:0] w_cur;
    logic [31:0] t1, t2;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    // byte writes: from input or from padding
    always_comb
    begin
        byte_we   = 1'b0;
        byte_addr = pos_reg;
        byte_val  = sha256_pkg::PAD_BYTE;
        if (take && in_data.has_byte)
        begin
            byte_we  = 1'b1;
            byte_val = in_data.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            byte_we  = 1'b1;
            byte_val = (cnt_reg == 4'd1) ? sha256_pkg::PAD_BYTE : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            unique case (byte_addr[1:0])
                2'd0: blk_mem[byte_addr[5:2]][31:24] <= byte_val;
                2'd1: blk_mem[byte_addr[5:2]][23:16] <= byte_val;
                2'd2: blk_mem[byte_addr[5:2]][15:8]  <= byte_val;
                default: blk_mem[byte_addr[5:2]][7:0] <= byte_val;
            endcase
        end
        rd_data_reg <= blk_mem[rd_addr];
    end

    // round r < 16 reads word r; address for next cycle
    assign rd_addr = rnd_reg[3:0];

    always_comb
    begin
        if (rnd_reg < 7'(sha256_pkg::BLOCK_WORDS + 1))
            w_cur = (rnd_reg == 7'(sha256_pkg::LEN_WORD + 1) && last_blk_reg) ?
                        len_reg[63:32] :
                    (rnd_reg == 7'(sha256_pkg::LEN_WORD + 2) && last_blk_reg) ?
                        len_reg[31:0] : rd_data_reg;
        else
            w_cur = sha256_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                  + sha256_pkg::small_sigma0(w_reg[1]) + w_reg[0];
    end

    always_comb
    begin
        t1 = r_reg[7] + sha256_pkg::big_sigma1(r_reg[4])
           + ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]))
           + sha256_pkg::ROUND_K[rnd_reg[5:0] - 6'd1] + w_cur;
        t2 = sha256_pkg::big_sigma0(r_reg[0])
           + ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    if (in_data.has_byte && pos_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (in_data.end_of_message)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (pos_reg == 6'd63 || pos_reg == 6'd55)
                    state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 7'(sha256_pkg::ROUNDS)) state_next = ST_ADD;
            ST_ADD:
                if (last_blk_reg)     state_next = ST_OUT;
                else if (finish_reg)  state_next = ST_PAD;
                else                  state_next = ST_IDLE;
            ST_OUT:
                if (out_ready && oidx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            len_reg      <= '0;
            rnd_reg      <= '0;
            cnt_reg      <= '0;
            finish_reg   <= 1'b0;
            last_blk_reg <= 1'b0;
            oidx_reg     <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha256_pkg::INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg <= '0;
                    if (take)
                    begin
                        finish_reg <= in_data.end_of_message;
                        cnt_reg    <= 4'd1;
                        if (in_data.has_byte)
                        begin
                            pos_reg <= pos_reg + 6'd1;
                            len_reg <= len_reg + 64'd8;
                        end
                        if (in_data.has_byte && pos_reg == 6'd63)
                            last_blk_reg <= 1'b0;
                    end
                end
                ST_PAD:
                begin
                    // cnt 1: pad byte written; then zeros up to 55 or 63
                    cnt_reg <= 4'd2;
                    rnd_reg <= '0;
                    if (pos_reg == 6'd55)
                    begin
                        last_blk_reg <= 1'b1;
                        pos_reg      <= '0;
                    end
                    else
                        pos_reg <= pos_reg + 6'd1;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd0)
                    begin
                        for (int i = 0; i < 8; i++)
                            r_reg[i] <= hash_reg[i];
                    end
                    else
                    begin
                        r_reg[7] <= r_reg[6];
                        r_reg[6] <= r_reg[5];
                        r_reg[5] <= r_reg[4];
                        r_reg[4] <= r_reg[3] + t1;
                        r_reg[3] <= r_reg[2];
                        r_reg[2] <= r_reg[1];
                        r_reg[1] <= r_reg[0];
                        r_reg[0] <= t1 + t2;
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i + 1];
                        w_reg[15] <= w_cur;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + r_reg[i];
                    cnt_reg  <= 4'd0;
                    oidx_reg <= '0;
                    if (finish_reg && !last_blk_reg && cnt_reg == 4'd1)
                        cnt_reg <= 4'd1;
                end
                ST_OUT:
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= sha256_pkg::INIT_HASH[i];
                            pos_reg      <= '0;
                            len_reg      <= '0;
                            finish_reg   <= 1'b0;
                            last_blk_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    assign out_valid            = (state_reg == ST_OUT);
    assign out_data.digest_word = hash_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

endmodule

// ===== rtl/sha256_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input sha256_pkg::out_beat_t out_data
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest pending");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
        else $error("last_word mismatch");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_word) |=>
        (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
        else $error("digest index skipped");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_data.word_index == 3'd0)
        else $error("digest does not start at word 0");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
